// File: src/pgs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pgs_pkg;

  localparam int NODES = 64;
  localparam int AW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 31;
  localparam int STEP_W = 6;

  localparam logic [1:0] REG_GAIN = 2'd0;
  localparam logic [1:0] REG_DT = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  localparam logic [15:0] GAIN_RESET = 16'd6554;
  localparam logic [15:0] DT_RESET = 16'd6554;
  localparam logic [6:0] COUNT_RESET = 7'd50;

  localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } iter_op_e;

  typedef struct packed {
    logic        start;
    iter_op_e    op;
    logic [64:0] num;
    logic [63:0] den;
    logic [30:0] low;
  } iter_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] res;
  } iter_rsp_t;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [7:0]  r;
  } body_t;

  typedef struct packed {
    logic [31:0] fx;
    logic [31:0] fy;
  } force_t;

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] res;
    if ((v[33] == v[32]) && (v[32] == v[31])) begin
      res = v[31:0];
    end else if (v[33]) begin
      res = NEG_MAX;
    end else begin
      res = POS_MAX;
    end
    return res;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    logic [31:0] res;
    res = v[31] ? 32'(-v) : v;
    return res;
  endfunction

  // Product of a magnitude and the time step, given its sign and floored to Q16.16.
  function automatic logic signed [32:0] scale_floor(input logic neg, input logic [63:0] m);
    logic [32:0] t;
    logic signed [32:0] res;
    t = {1'b0, m[47:16]} + 33'(neg && (m[15:0] != 16'd0));
    res = neg ? $signed(-t) : $signed(t);
    return res;
  endfunction

endpackage

`default_nettype wire

// File: src/pgs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pgs_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/pgs_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module pgs_mul import pgs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// File: src/pgs_iter.sv
`timescale 1ns / 1ps
`default_nettype none

module pgs_iter import pgs_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire iter_req_t req_i,
  output iter_rsp_t      rsp_o
);

  logic              busy_q;
  logic              done_q;
  iter_op_e          op_q;
  logic [STEP_W-1:0] cnt_q;
  logic [64:0]       acc_q;
  logic [63:0]       root_q;
  logic [63:0]       bit_q;
  logic [63:0]       den_q;
  logic [30:0]       low_q;

  logic [63:0] sq_t;
  logic        sq_ge;
  logic [64:0] dv_rem;
  logic        dv_ge;

  assign sq_t = root_q + bit_q;
  assign sq_ge = acc_q[63:0] >= sq_t;
  assign dv_rem = {acc_q[63:0], low_q[30]};
  assign dv_ge = dv_rem >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q <= OP_SQRT;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        op_q <= req_i.op;
        acc_q <= req_i.num;
        den_q <= req_i.den;
        low_q <= req_i.low;
        root_q <= '0;
        bit_q <= 64'h4000_0000_0000_0000;
        cnt_q <= (req_i.op == OP_SQRT) ? STEP_W'(SQRT_STEPS - 1) : STEP_W'(DIV_STEPS - 1);
      end else if (busy_q) begin
        unique case (op_q)
          OP_SQRT: begin
            if (sq_ge) begin
              acc_q <= {1'b0, acc_q[63:0] - sq_t};
              root_q <= (root_q >> 1) + bit_q;
            end else begin
              root_q <= root_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end
          OP_DIV: begin
            acc_q <= dv_ge ? (dv_rem - {1'b0, den_q}) : dv_rem;
            root_q <= {root_q[62:0], dv_ge};
            low_q <= {low_q[29:0], 1'b0};
          end
          default: begin
            root_q <= root_q;
          end
        endcase
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - STEP_W'(1);
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.res = root_q[31:0];

endmodule

`default_nettype wire

// File: src/pairwise_gravity_step_top.sv
// Load request: written to the body store while idle; the block stays ready for the next request.
// Step request: each ordered pair of bodies in use goes through the shared iterative unit
// (a square root and up to three divisions), then each body is read and given an Euler update.
// One request at a time; results leave through an output register.
// Reset clears control and configuration; the body stores hold no defined value until loaded.
`timescale 1ns / 1ps
`default_nettype none

module pairwise_gravity_step_top import pgs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [5:0]  body_index_i,
  input  wire logic [31:0] load_pos_x_i,
  input  wire logic [31:0] load_pos_y_i,
  input  wire logic [31:0] load_vel_x_i,
  input  wire logic [31:0] load_vel_y_i,
  input  wire logic [7:0]  load_radius_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [5:0]       out_index_o,
  output logic [31:0]      out_pos_x_o,
  output logic [31:0]      out_pos_y_o,
  output logic [31:0]      out_vel_x_o,
  output logic [31:0]      out_vel_y_o,
  output logic             last_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_A, ST_LAT_A, ST_RD_B, ST_LAT_B, ST_SQX, ST_SQY, ST_D2, ST_SQRT,
    ST_K1, ST_K2, ST_K3, ST_MAG, ST_CMUL, ST_CCHK, ST_CDIV, ST_CADD, ST_NEXTJ,
    ST_U_RD, ST_U_LAT, ST_U_VMUL, ST_U_VADD, ST_U_PMUL, ST_U_PADD, ST_U_OUT
  } state_e;

  state_e state_q;

  logic [15:0]   gain_q;
  logic [15:0]   dt_q;
  logic [6:0]    count_q;
  logic [CW-1:0] n_q;
  logic [AW-1:0] i_q;
  logic [AW-1:0] j_q;
  logic          axis_q;

  logic [31:0]        bpx_q, bpy_q, bvx_q, bvy_q;
  logic [7:0]         br_q;
  logic [7:0]         rb_q;
  logic [31:0]        fx_q, fy_q;
  logic signed [32:0] dx_q, dy_q;
  logic [63:0]        sx_q;
  logic [63:0]        d2_q;
  logic [31:0]        d_q;
  logic [30:0]        mag_q;
  logic [30:0]        comp_q;

  logic        out_valid_q, last_q;
  logic [5:0]  out_index_q;
  logic [31:0] out_px_q, out_py_q, out_vx_q, out_vy_q;

  iter_req_t iter_req_q;
  iter_rsp_t iter_rsp;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  body_t         body_wd, body_rd;
  force_t        frc_wd, frc_rd;
  logic          body_we, frc_we;
  logic [AW-1:0] body_waddr, raddr;

  logic               in_fire, load_fire, step_fire, out_free;
  logic               last_i, last_j;
  logic signed [32:0] dsel;
  logic               dneg;
  logic [31:0]        dabs;
  logic [31:0]        fsel, vsel, psel;
  logic [64:0]        d2_sum;
  logic [63:0]        d2_val;
  logic [31:0]        k_val;
  logic [62:0]        prod;
  logic signed [33:0] comp_s;
  logic [31:0]        v_new, p_new;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire = in_valid_i && in_ready_o;
  assign load_fire = in_fire && !cmd_i && ({1'b0, body_index_i} < 7'(NODES));
  assign step_fire = in_fire && cmd_i;
  assign out_free = !out_valid_q || out_ready_i;

  assign last_i = (CW'(i_q) + CW'(1)) == n_q;
  assign last_j = (CW'(j_q) + CW'(1)) == n_q;

  assign dsel = axis_q ? dy_q : dx_q;
  assign dneg = dsel[32];
  assign dabs = dneg ? 32'(-dsel) : dsel[31:0];
  assign fsel = axis_q ? fy_q : fx_q;
  assign vsel = axis_q ? bvy_q : bvx_q;
  assign psel = axis_q ? bpy_q : bpx_q;

  assign d2_sum = {1'b0, sx_q} + {1'b0, mul_p};
  assign d2_val = d2_sum[64] ? '1 : d2_sum[63:0];
  assign k_val = mul_p[31:0];
  assign prod = mul_p[62:0];
  assign comp_s = dneg ? -$signed({3'b0, comp_q}) : $signed({3'b0, comp_q});

  assign v_new = sat32($signed({{2{vsel[31]}}, vsel})
                       + 34'(scale_floor(fsel[31], mul_p)));
  assign p_new = sat32($signed({{2{psel[31]}}, psel})
                       + 34'(scale_floor(vsel[31], mul_p)));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQX: begin
        mul_a = dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
        mul_b = mul_a;
      end
      ST_SQY: begin
        mul_a = dy_q[32] ? 32'(-dy_q) : dy_q[31:0];
        mul_b = mul_a;
      end
      ST_K1: begin
        mul_a = 32'(gain_q);
        mul_b = 32'(br_q);
      end
      ST_K2: begin
        mul_a = mul_p[31:0];
        mul_b = 32'(rb_q);
      end
      ST_CMUL: begin
        mul_a = 32'(mag_q);
        mul_b = dabs;
      end
      ST_U_VMUL: begin
        mul_a = abs32(fsel);
        mul_b = 32'(dt_q);
      end
      ST_U_PMUL: begin
        mul_a = abs32(vsel);
        mul_b = 32'(dt_q);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign raddr = (state_q == ST_RD_B) ? j_q : i_q;

  assign body_we = load_fire || ((state_q == ST_U_OUT) && out_free);
  assign body_waddr = load_fire ? body_index_i[AW-1:0] : i_q;
  always_comb begin
    if (load_fire) begin
      body_wd = '{px: load_pos_x_i, py: load_pos_y_i, vx: load_vel_x_i,
                  vy: load_vel_y_i, r: load_radius_i};
    end else begin
      body_wd = '{px: bpx_q, py: bpy_q, vx: bvx_q, vy: bvy_q, r: br_q};
    end
  end

  assign frc_we = (state_q == ST_NEXTJ) && last_j;
  assign frc_wd = '{fx: fx_q, fy: fy_q};

  pgs_ram #(.Width($bits(body_t)), .Depth(NODES)) u_body_ram (
    .clk_i   (clk_i),
    .we_i    (body_we),
    .waddr_i (body_waddr),
    .wdata_i (body_wd),
    .raddr_i (raddr),
    .rdata_o (body_rd)
  );

  pgs_ram #(.Width($bits(force_t)), .Depth(NODES)) u_force_ram (
    .clk_i   (clk_i),
    .we_i    (frc_we),
    .waddr_i (i_q),
    .wdata_i (frc_wd),
    .raddr_i (raddr),
    .rdata_o (frc_rd)
  );

  pgs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  pgs_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iter_req_q),
    .rsp_o  (iter_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      gain_q <= GAIN_RESET;
      dt_q <= DT_RESET;
      count_q <= COUNT_RESET;
      n_q <= '0;
      i_q <= '0;
      j_q <= '0;
      axis_q <= 1'b0;
      out_valid_q <= 1'b0;
      last_q <= 1'b0;
      iter_req_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_U_OUT)) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_GAIN:  gain_q <= cfg_data_i;
          REG_DT:    dt_q <= cfg_data_i;
          REG_COUNT: count_q <= cfg_data_i[6:0];
          default:   gain_q <= gain_q;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (step_fire && (count_q != 7'd0)) begin
            n_q <= (count_q > 7'(NODES)) ? CW'(NODES) : CW'(count_q);
            i_q <= '0;
            state_q <= ST_RD_A;
          end
        end
        ST_RD_A: begin
          state_q <= ST_LAT_A;
        end
        ST_LAT_A: begin
          bpx_q <= body_rd.px;
          bpy_q <= body_rd.py;
          br_q <= body_rd.r;
          fx_q <= '0;
          fy_q <= '0;
          j_q <= '0;
          state_q <= ST_RD_B;
        end
        ST_RD_B: begin
          state_q <= (j_q == i_q) ? ST_NEXTJ : ST_LAT_B;
        end
        ST_LAT_B: begin
          dx_q <= $signed({body_rd.px[31], body_rd.px}) - $signed({bpx_q[31], bpx_q});
          dy_q <= $signed({body_rd.py[31], body_rd.py}) - $signed({bpy_q[31], bpy_q});
          rb_q <= body_rd.r;
          state_q <= ST_SQX;
        end
        ST_SQX: begin
          state_q <= ST_SQY;
        end
        ST_SQY: begin
          sx_q <= mul_p;
          state_q <= ST_D2;
        end
        ST_D2: begin
          d2_q <= d2_val;
          if (d2_val == 64'd0) begin
            state_q <= ST_NEXTJ;
          end else begin
            iter_req_q <= '{start: 1'b1, op: OP_SQRT, num: {1'b0, d2_val}, den: '0, low: '0};
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          iter_req_q.start <= 1'b0;
          if (iter_rsp.done) begin
            d_q <= iter_rsp.res;
            state_q <= ST_K1;
          end
        end
        ST_K1: begin
          state_q <= ST_K2;
        end
        ST_K2: begin
          state_q <= ST_K3;
        end
        ST_K3: begin
          axis_q <= 1'b0;
          if ({1'b0, d2_q} <= {32'd0, k_val, 1'b0}) begin
            mag_q <= POS_MAX[30:0];
            state_q <= ST_CMUL;
          end else begin
            iter_req_q <= '{start: 1'b1, op: OP_DIV, num: {32'd0, k_val, 1'b0},
                            den: d2_q, low: '0};
            state_q <= ST_MAG;
          end
        end
        ST_MAG: begin
          iter_req_q.start <= 1'b0;
          if (iter_rsp.done) begin
            mag_q <= iter_rsp.res[30:0];
            state_q <= ST_CMUL;
          end
        end
        ST_CMUL: begin
          state_q <= ST_CCHK;
        end
        ST_CCHK: begin
          if (prod[62:31] >= d_q) begin
            comp_q <= POS_MAX[30:0];
            state_q <= ST_CADD;
          end else begin
            iter_req_q <= '{start: 1'b1, op: OP_DIV, num: {33'd0, prod[62:31]},
                            den: {32'd0, d_q}, low: prod[30:0]};
            state_q <= ST_CDIV;
          end
        end
        ST_CDIV: begin
          iter_req_q.start <= 1'b0;
          if (iter_rsp.done) begin
            comp_q <= iter_rsp.res[30:0];
            state_q <= ST_CADD;
          end
        end
        ST_CADD: begin
          if (!axis_q) begin
            fx_q <= sat32($signed({{2{fx_q[31]}}, fx_q}) + comp_s);
            axis_q <= 1'b1;
            state_q <= ST_CMUL;
          end else begin
            fy_q <= sat32($signed({{2{fy_q[31]}}, fy_q}) + comp_s);
            state_q <= ST_NEXTJ;
          end
        end
        ST_NEXTJ: begin
          if (last_j) begin
            if (last_i) begin
              i_q <= '0;
              state_q <= ST_U_RD;
            end else begin
              i_q <= i_q + AW'(1);
              state_q <= ST_RD_A;
            end
          end else begin
            j_q <= j_q + AW'(1);
            state_q <= ST_RD_B;
          end
        end
        ST_U_RD: begin
          state_q <= ST_U_LAT;
        end
        ST_U_LAT: begin
          bpx_q <= body_rd.px;
          bpy_q <= body_rd.py;
          bvx_q <= body_rd.vx;
          bvy_q <= body_rd.vy;
          br_q <= body_rd.r;
          fx_q <= frc_rd.fx;
          fy_q <= frc_rd.fy;
          axis_q <= 1'b0;
          state_q <= ST_U_VMUL;
        end
        ST_U_VMUL: begin
          state_q <= ST_U_VADD;
        end
        ST_U_VADD: begin
          if (axis_q) begin
            bvy_q <= v_new;
          end else begin
            bvx_q <= v_new;
          end
          state_q <= ST_U_PMUL;
        end
        ST_U_PMUL: begin
          state_q <= ST_U_PADD;
        end
        ST_U_PADD: begin
          if (axis_q) begin
            bpy_q <= p_new;
            state_q <= ST_U_OUT;
          end else begin
            bpx_q <= p_new;
            axis_q <= 1'b1;
            state_q <= ST_U_VMUL;
          end
        end
        ST_U_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_index_q <= 6'(i_q);
            out_px_q <= bpx_q;
            out_py_q <= bpy_q;
            out_vx_q <= bvx_q;
            out_vy_q <= bvy_q;
            last_q <= last_i;
            if (last_i) begin
              state_q <= ST_IDLE;
            end else begin
              i_q <= i_q + AW'(1);
              state_q <= ST_U_RD;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_pos_x_o = out_px_q;
  assign out_pos_y_o = out_py_q;
  assign out_vel_x_o = out_vx_q;
  assign out_vel_y_o = out_vy_q;
  assign last_o = last_q;

  a_new_result_from_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_U_OUT))
    else $error("result appeared outside the update phase");

  a_idle_unit_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !iter_rsp.busy)
    else $error("iterative unit busy while accepting requests");

  a_last_ends_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_o) && last_o) |-> (state_q == ST_IDLE))
    else $error("final body emitted but the step did not finish");

endmodule

`default_nettype wire

// File: tb/pgs_checker.sv
`timescale 1ns / 1ps

module pgs_checker import pgs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        cmd_i,
  input  logic [5:0]  body_index_i,
  input  logic [31:0] load_pos_x_i,
  input  logic [31:0] load_pos_y_i,
  input  logic [31:0] load_vel_x_i,
  input  logic [31:0] load_vel_y_i,
  input  logic [7:0]  load_radius_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [5:0]  out_index_i,
  input  logic [31:0] out_pos_x_i,
  input  logic [31:0] out_pos_y_i,
  input  logic [31:0] out_vel_x_i,
  input  logic [31:0] out_vel_y_i,
  input  logic        last_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [5:0]  index;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic        last;
  } body_result_t;

  body_result_t updated_bodies_q[$];

  logic signed [31:0] pos_x[NODES];
  logic signed [31:0] pos_y[NODES];
  logic signed [31:0] vel_x[NODES];
  logic signed [31:0] vel_y[NODES];
  logic [7:0]         radius[NODES];
  logic [15:0]        gain;
  logic [15:0]        dt;
  logic [6:0]         count;

  int errors;

  assign errors_o = errors;
  assign pending_o = updated_bodies_q.size();

  initial begin
    errors = 0;
    gain = GAIN_RESET;
    dt = DT_RESET;
    count = COUNT_RESET;
    for (int i = 0; i < NODES; i++) begin
      pos_x[i] = '0;
      pos_y[i] = '0;
      vel_x[i] = '0;
      vel_y[i] = '0;
      radius[i] = '0;
    end
  end

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint times_dt(input longint a);
    longint p;
    p = a * longint'({48'd0, dt});
    return p >>> 16;
  endfunction

  function automatic longint pull_component(input longint diff, input longint unsigned mag,
                                            input longint unsigned span);
    longint unsigned ad;
    longint unsigned c;
    ad = diff < 0 ? longint'(-diff) : longint'(diff);
    c = (mag * ad) / span;
    if (c > 64'd2147483647) begin
      c = 64'd2147483647;
    end
    return diff < 0 ? -longint'(c) : longint'(c);
  endfunction

  task automatic predict_step();
    int n;
    longint dx, dy;
    longint unsigned ax, ay, sx, sy, d2, d, k, mag;
    logic signed [31:0] fx[NODES];
    logic signed [31:0] fy[NODES];
    logic signed [31:0] nvx, nvy, npx, npy;
    body_result_t r;
    n = (count > NODES) ? NODES : count;
    for (int a = 0; a < n; a++) begin
      fx[a] = '0;
      fy[a] = '0;
      for (int b = 0; b < n; b++) begin
        if (b != a) begin
          dx = longint'(pos_x[b]) - longint'(pos_x[a]);
          dy = longint'(pos_y[b]) - longint'(pos_y[a]);
          ax = dx < 0 ? -dx : dx;
          ay = dy < 0 ? -dy : dy;
          sx = ax * ax;
          sy = ay * ay;
          d2 = (sx > 64'hffff_ffff_ffff_ffff - sy) ? 64'hffff_ffff_ffff_ffff : sx + sy;
          if (d2 != 0) begin
            d = floor_sqrt(d2);
            k = longint'(gain) * longint'(radius[a]) * longint'(radius[b]);
            mag = (k << 32) / d2;
            if (mag > 64'd2147483647) begin
              mag = 64'd2147483647;
            end
            fx[a] = clamp32(longint'(fx[a]) + pull_component(dx, mag, d));
            fy[a] = clamp32(longint'(fy[a]) + pull_component(dy, mag, d));
          end
        end
      end
    end
    for (int a = 0; a < n; a++) begin
      nvx = clamp32(longint'(vel_x[a]) + times_dt(longint'(fx[a])));
      nvy = clamp32(longint'(vel_y[a]) + times_dt(longint'(fy[a])));
      npx = clamp32(longint'(pos_x[a]) + times_dt(longint'(nvx)));
      npy = clamp32(longint'(pos_y[a]) + times_dt(longint'(nvy)));
      vel_x[a] = nvx;
      vel_y[a] = nvy;
      pos_x[a] = npx;
      pos_y[a] = npy;
      r.index = a[5:0];
      r.px = npx;
      r.py = npy;
      r.vx = nvx;
      r.vy = nvy;
      r.last = (a + 1 == n);
      updated_bodies_q = {updated_bodies_q, r};
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    body_result_t e;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_GAIN:  gain = cfg_data_i;
          REG_DT:    dt = cfg_data_i;
          REG_COUNT: count = cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (cmd_i) begin
          predict_step();
        end else begin
          pos_x[body_index_i] = load_pos_x_i;
          pos_y[body_index_i] = load_pos_y_i;
          vel_x[body_index_i] = load_vel_x_i;
          vel_y[body_index_i] = load_vel_y_i;
          radius[body_index_i] = load_radius_i;
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (updated_bodies_q.size() == 0) begin
          $error("unexpected result for body %0d", out_index_i);
          errors++;
        end else begin
          e = updated_bodies_q.pop_front();
          compare_field("out_index", 32'(e.index), 32'(out_index_i));
          compare_field("out_pos_x", e.px, out_pos_x_i);
          compare_field("out_pos_y", e.py, out_pos_y_i);
          compare_field("out_vel_x", e.vx, out_vel_x_i);
          compare_field("out_vel_y", e.vy, out_vel_y_i);
          compare_field("last", 32'(e.last), 32'(last_i));
        end
      end
    end
  end

endmodule

// File: tb/tb_pairwise_gravity_step_top.sv
`timescale 1ns / 1ps

module tb_pairwise_gravity_step_top;
  import pgs_pkg::*;

  localparam int CYCLE_LIMIT = 10000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_GAIN;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_i = 1'b0;
  logic [5:0]  body_index_i = '0;
  logic [31:0] load_pos_x_i = '0;
  logic [31:0] load_pos_y_i = '0;
  logic [31:0] load_vel_x_i = '0;
  logic [31:0] load_vel_y_i = '0;
  logic [7:0]  load_radius_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [5:0]  out_index_o;
  logic [31:0] out_pos_x_o;
  logic [31:0] out_pos_y_o;
  logic [31:0] out_vel_x_o;
  logic [31:0] out_vel_y_o;
  logic        last_o;

  int errors;
  int pending;
  int cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;

  pairwise_gravity_step_top u_dut (.*);

  pgs_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .body_index_i,
    .load_pos_x_i, .load_pos_y_i, .load_vel_x_i, .load_vel_y_i, .load_radius_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_index_i(out_index_o),
    .out_pos_x_i(out_pos_x_o), .out_pos_y_i(out_pos_y_o),
    .out_vel_x_i(out_vel_x_o), .out_vel_y_i(out_vel_y_o), .last_i(last_o),
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles % 97 == 0) begin
      stall_mode <= $urandom_range(0, 2);
    end
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
    endcase
  endfunction

  task automatic send_request(input logic cmd, input logic [5:0] idx, input logic [31:0] px,
                              input logic [31:0] py, input logic [31:0] vx,
                              input logic [31:0] vy, input logic [7:0] r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    body_index_i <= idx;
    load_pos_x_i <= px;
    load_pos_y_i <= py;
    load_vel_x_i <= vx;
    load_vel_y_i <= vy;
    load_radius_i <= r;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic load_random(input logic [5:0] idx);
    send_request(1'b0, idx, pick_value(), pick_value(), pick_value(), pick_value(),
                 8'($urandom_range(0, 255)));
  endtask

  task automatic run_step();
    send_request(1'b1, 6'($urandom), $urandom, $urandom, $urandom, $urandom,
                 8'($urandom));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_all(input logic [15:0] g, input logic [15:0] t, input logic [6:0] n);
    wait_idle();
    write_reg(REG_GAIN, g);
    write_reg(REG_DT, t);
    write_reg(REG_COUNT, {9'd0, n});
  endtask

  initial begin
    int n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_all(16'hffff, 16'hffff, 7'd2);
    send_request(1'b0, 6'd0, 32'd0, 32'd0, 32'h7fff_ffff, 32'h8000_0000, 8'd255);
    send_request(1'b0, 6'd1, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 8'd255);
    run_step();
    send_request(1'b0, 6'd1, 32'd5, 32'd7, 32'h1234_5678, 32'hfedc_ba98, 8'd200);
    send_request(1'b0, 6'd0, 32'd5, 32'd7, 32'd0, 32'hffff_ffff, 8'd1);
    run_step();
    send_request(1'b0, 6'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'd0, 32'd0, 8'd0);
    send_request(1'b0, 6'd1, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0, 8'd255);
    run_step();
    send_request(1'b0, 6'd0, 32'h8000_0000, 32'h0000_8000, 32'h8000_0000, 32'd1, 8'd255);
    send_request(1'b0, 6'd1, 32'h7fff_ffff, 32'hffff_8000, 32'h7fff_ffff, 32'd0, 8'd128);
    run_step();
    send_request(1'b0, 6'd63, '1, '1, '1, '1, '1);
    send_request(1'b0, 6'd62, '0, '0, '0, '0, '0);
    set_all(16'd0, 16'd0, 7'd0);
    run_step();
    set_all(GAIN_RESET, DT_RESET, 7'd1);
    run_step();
    run_step();

    for (int ph = 0; ph < 6; ph++) begin
      n = $urandom_range(1, 6);
      set_all(ph == 1 ? 16'd0 : 16'($urandom), ph == 2 ? 16'd0 : 16'($urandom), 7'(n));
      for (int i = 0; i < n; i++) load_random(6'(i));
      repeat ($urandom_range(4, 10)) begin
        if ($urandom_range(0, 9) < 6) begin
          run_step();
        end else begin
          load_random(6'($urandom_range(0, 63)));
        end
      end
    end

    set_all(16'd3000, 16'd4000, 7'd64);
    write_reg(REG_COUNT, 16'd127);
    for (int i = 0; i < NODES; i++) load_random(6'(i));
    run_step();

    wait_idle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
